[design/rhbc_pkg.sv]
`timescale 1ns / 1ps

package rhbc_pkg;

    // Input word: one world position, signed Q16.16
    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_z;
    } rhbc_in_t;

    // Result word
    typedef struct packed {
        logic [3:0]  biome_index;
        logic        table_empty;
        logic [23:0] moisture;
        logic [23:0] roughness;
        logic [23:0] elevation;
    } rhbc_out_t;

    // Classification results carried alongside the fallback hash and modulo
    typedef struct packed {
        logic [23:0] moisture;
        logic [23:0] roughness;
        logic [23:0] elevation;
        logic [4:0]  slot;
        logic        slot_hit;
    } rhbc_side_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_SEED           = 3'd0,
        REG_REGION_SCALE   = 3'd1,
        REG_BIOME_COUNT    = 3'd2,
        REG_ROCKY_SLOT     = 3'd3,
        REG_SPARSE_SLOT    = 3'd4,
        REG_CAMP_SLOT      = 3'd5,
        REG_GRASSLAND_SLOT = 3'd6
    } rhbc_reg_t;

    localparam int RHBC_MAX_BIOMES = 16;

    // Scale floor (0.001 in Q16.16) and reset values
    localparam logic [24:0] RHBC_MIN_SCALE   = 25'd66;
    localparam logic [24:0] RHBC_SCALE_RESET = 25'd65536;
    localparam logic [4:0]  RHBC_SLOT_ABSENT = 5'd16;

    // Hash multipliers
    localparam logic [31:0] RHBC_MUL_X    = 32'h9e3779b1;
    localparam logic [31:0] RHBC_MUL_Z    = 32'h85ebca6b;
    localparam logic [31:0] RHBC_MUL_SEED = 32'h27d4eb2d;
    localparam logic [31:0] RHBC_MUL_SALT = 32'hc2b2ae35;
    localparam logic [31:0] RHBC_MUL_FIN1 = 32'h7feb352d;
    localparam logic [31:0] RHBC_MUL_FIN2 = 32'h846ca68b;

    // salt * RHBC_MUL_SALT, low 32 bits, per salt
    localparam logic [63:0] RHBC_K17_W = 64'd17 * 64'(RHBC_MUL_SALT);
    localparam logic [63:0] RHBC_K41_W = 64'd41 * 64'(RHBC_MUL_SALT);
    localparam logic [63:0] RHBC_K73_W = 64'd73 * 64'(RHBC_MUL_SALT);
    localparam logic [63:0] RHBC_K3_W  = 64'd3 * 64'(RHBC_MUL_SALT);
    localparam logic [63:0] RHBC_K5_W  = 64'd5 * 64'(RHBC_MUL_SALT);
    localparam logic [63:0] RHBC_K7_W  = 64'd7 * 64'(RHBC_MUL_SALT);
    localparam logic [63:0] RHBC_K11_W = 64'd11 * 64'(RHBC_MUL_SALT);
    localparam logic [31:0] RHBC_KEY_MOIST = RHBC_K17_W[31:0];
    localparam logic [31:0] RHBC_KEY_ROUGH = RHBC_K41_W[31:0];
    localparam logic [31:0] RHBC_KEY_ELEV  = RHBC_K73_W[31:0];
    localparam logic [31:0] RHBC_KEY_ROCKY = RHBC_K3_W[31:0];
    localparam logic [31:0] RHBC_KEY_SPARSE = RHBC_K5_W[31:0];
    localparam logic [31:0] RHBC_KEY_CAMP  = RHBC_K7_W[31:0];
    localparam logic [31:0] RHBC_KEY_GRASS = RHBC_K11_W[31:0];

    // Thresholds: h*100 > p*FS  <=>  h > floor(p*FS/100)
    //             h*100 < p*FS  <=>  h < ceil(p*FS/100)
    localparam longint RHBC_FULL_SCALE = 64'd16777215;
    localparam longint RHBC_ROCKY_N  = (68 * RHBC_FULL_SCALE) / 100;
    localparam longint RHBC_SPARSE_N = (28 * RHBC_FULL_SCALE + 99) / 100;
    localparam longint RHBC_ELEV_N   = (72 * RHBC_FULL_SCALE) / 100;
    localparam longint RHBC_MOIST_N  = (45 * RHBC_FULL_SCALE) / 100;
    localparam logic [23:0] RHBC_ROCKY_TH  = RHBC_ROCKY_N[23:0];
    localparam logic [23:0] RHBC_SPARSE_TH = RHBC_SPARSE_N[23:0];
    localparam logic [23:0] RHBC_ELEV_TH   = RHBC_ELEV_N[23:0];
    localparam logic [23:0] RHBC_MOIST_TH  = RHBC_MOIST_N[23:0];

    // Modulo pipeline: dividend bits retired per stage
    localparam int RHBC_MOD_STEP   = 4;
    localparam int RHBC_MOD_STAGES = 32 / RHBC_MOD_STEP;

    // Cell mult, hash base, mix a/b, classify, fallback mix a/b, modulo, output
    localparam int RHBC_LATENCY = 7 + RHBC_MOD_STAGES + 1;

endpackage

[design/rhbc_mix.sv]
`timescale 1ns / 1ps

// Hash finalizer: salt key, fold, two multiplies, fold. Two register stages.
module rhbc_mix
    import rhbc_pkg::*;
(
    input  logic        clk,
    input  logic [31:0] base,
    input  logic [31:0] salt_key,
    output logic [31:0] hash
);

    logic [31:0] fold_a;
    logic [31:0] fold_b;
    logic [31:0] mul_a_reg;
    logic [31:0] mul_a_next;
    logic [31:0] mul_b_reg;
    logic [31:0] mul_b_next;

    // Stage a: XOR in salt key, fold high half down, first multiply
    always_comb
    begin
        fold_a     = base ^ salt_key;
        fold_a     = fold_a ^ (fold_a >> 16);
        mul_a_next = fold_a * RHBC_MUL_FIN1;
    end

    // Stage b: fold by 15, second multiply
    always_comb
    begin
        fold_b     = mul_a_reg ^ (mul_a_reg >> 15);
        mul_b_next = fold_b * RHBC_MUL_FIN2;
    end

    always_ff @(posedge clk)
    begin
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
    end

    // Final fold
    assign hash = mul_b_reg ^ (mul_b_reg >> 16);

endmodule

[design/rhbc_mod.sv]
`timescale 1ns / 1ps

// Pipelined restoring remainder of a 32-bit word by a divisor up to 31.
// Each stage retires RHBC_MOD_STEP dividend bits; divisor must be static config (not enforced here).
module rhbc_mod
    import rhbc_pkg::*;
(
    input  logic        clk,
    input  logic [31:0] dividend,
    input  logic [4:0]  divisor,
    output logic [4:0]  remainder
);

    logic [4:0]  rem_reg [RHBC_MOD_STAGES];
    logic [31:0] num_reg [RHBC_MOD_STAGES];

    genvar j;
    generate
        for (j = 0; j < RHBC_MOD_STAGES; j++)
        begin : g_stage
            logic [4:0]  rem_in;
            logic [31:0] num_in;
            logic [4:0]  rem_next;
            logic [31:0] num_next;

            if (j == 0)
            begin : g_first
                assign rem_in = 5'd0;
                assign num_in = dividend;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[j-1];
                assign num_in = num_reg[j-1];
            end

            // Shift in RHBC_MOD_STEP bits one at a time, subtract divisor when it fits
            always_comb
            begin
                logic [5:0] trial;
                rem_next = rem_in;
                for (int k = 0; k < RHBC_MOD_STEP; k++)
                begin
                    trial = {rem_next, num_in[5'(31 - k)]};
                    if (trial >= {1'b0, divisor})
                    begin
                        trial = trial - {1'b0, divisor};
                    end
                    rem_next = trial[4:0];
                end
                num_next = num_in << RHBC_MOD_STEP;
            end

            always_ff @(posedge clk)
            begin
                rem_reg[j] <= rem_next;
                num_reg[j] <= num_next;
            end
        end
    endgenerate

    assign remainder = rem_reg[RHBC_MOD_STAGES-1];

endmodule

[design/region_hash_biome_classifier.sv]
`timescale 1ns / 1ps

// Handshake: done comes from the end of the valid shift register and rises with the registered result word.
// Throughput: one word per cycle while busy is low; the pipeline never stalls and the receiver cannot stall.
// The depth is set by the 8-stage remainder pipeline after two chained hash finalizers.
// Reset clears the pipeline valid bits and loads register defaults; busy is high during
// reset and until the first clock edge after it, then stays low.
module region_hash_biome_classifier
    import rhbc_pkg::*;
#(
    parameter int MAX_BIOMES = RHBC_MAX_BIOMES
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  rhbc_in_t   item,
    output logic       done,
    output rhbc_out_t  result,
    input  logic       cfg_write,
    input  logic [2:0] cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int SIDE_DEPTH = 2 + RHBC_MOD_STAGES;

    // Configuration registers
    logic [31:0] seed_reg;
    logic [24:0] region_scale_reg;
    logic [4:0]  biome_count_reg;
    logic [4:0]  rocky_slot_reg;
    logic [4:0]  sparse_slot_reg;
    logic [4:0]  camp_slot_reg;
    logic [4:0]  grassland_slot_reg;

    logic busy_reg;
    logic accept;
    logic [RHBC_LATENCY-1:0] valid_reg;

    logic [4:0]  count;
    logic [24:0] scale_eff;

    logic signed [57:0] prod_x;
    logic signed [57:0] prod_z;
    logic [31:0] cell_x_reg;
    logic [31:0] cell_z_reg;
    logic [31:0] base_reg;
    logic [31:0] base_next;
    logic [31:0] base_d1_reg;
    logic [31:0] base_d2_reg;
    logic [31:0] base_d3_reg;

    logic [31:0] hash_moist;
    logic [31:0] hash_rough;
    logic [31:0] hash_elev;
    logic [31:0] hash_fall;

    rhbc_side_t  side_next;
    rhbc_side_t  side_reg [SIDE_DEPTH+1];
    logic [31:0] fall_key_reg;
    logic [31:0] fall_key_next;

    logic [4:0]  mod_rem;
    logic [4:0]  idx;
    rhbc_out_t   result_reg;
    rhbc_out_t   result_next;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg           <= 32'd0;
            region_scale_reg   <= RHBC_SCALE_RESET;
            biome_count_reg    <= 5'd0;
            rocky_slot_reg     <= RHBC_SLOT_ABSENT;
            sparse_slot_reg    <= RHBC_SLOT_ABSENT;
            camp_slot_reg      <= RHBC_SLOT_ABSENT;
            grassland_slot_reg <= RHBC_SLOT_ABSENT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SEED:           seed_reg           <= cfg_data;
                REG_REGION_SCALE:   region_scale_reg   <= cfg_data[24:0];
                REG_BIOME_COUNT:    biome_count_reg    <= cfg_data[4:0];
                REG_ROCKY_SLOT:     rocky_slot_reg     <= cfg_data[4:0];
                REG_SPARSE_SLOT:    sparse_slot_reg    <= cfg_data[4:0];
                REG_CAMP_SLOT:      camp_slot_reg      <= cfg_data[4:0];
                REG_GRASSLAND_SLOT: grassland_slot_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Effective count and scale (config must be static while words are in flight; not enforced)
    always_comb
    begin
        count = biome_count_reg;
        if (int'(biome_count_reg) > MAX_BIOMES)
        begin
            count = 5'(MAX_BIOMES);
        end
        scale_eff = (region_scale_reg < RHBC_MIN_SCALE) ? RHBC_MIN_SCALE : region_scale_reg;
    end

    // Handshake and valid pipeline
    assign accept = start && !busy_reg;
    assign busy   = busy_reg;
    assign done   = valid_reg[RHBC_LATENCY-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            valid_reg <= '0;
        end
        else
        begin
            busy_reg  <= 1'b0;
            valid_reg <= {valid_reg[RHBC_LATENCY-2:0], accept};
        end
    end

    // Stage 1: floor(world * scale), wrapped to 32 bits
    assign prod_x = item.world_x * $signed({1'b0, scale_eff});
    assign prod_z = item.world_z * $signed({1'b0, scale_eff});

    // Stage 2: shared hash base for every salt
    assign base_next = (cell_x_reg * RHBC_MUL_X) ^ (cell_z_reg * RHBC_MUL_Z)
                     ^ (seed_reg * RHBC_MUL_SEED);

    always_ff @(posedge clk)
    begin
        cell_x_reg  <= {{6{prod_x[57]}}, prod_x[57:32]};
        cell_z_reg  <= {{6{prod_z[57]}}, prod_z[57:32]};
        base_reg    <= base_next;
        base_d1_reg <= base_reg;
        base_d2_reg <= base_d1_reg;
        base_d3_reg <= base_d2_reg;
    end

    // Stages 3-4: the three field hashes
    rhbc_mix u_mix_moist
    (
        .clk      (clk),
        .base     (base_reg),
        .salt_key (RHBC_KEY_MOIST),
        .hash     (hash_moist)
    );

    rhbc_mix u_mix_rough
    (
        .clk      (clk),
        .base     (base_reg),
        .salt_key (RHBC_KEY_ROUGH),
        .hash     (hash_rough)
    );

    rhbc_mix u_mix_elev
    (
        .clk      (clk),
        .base     (base_reg),
        .salt_key (RHBC_KEY_ELEV),
        .hash     (hash_elev)
    );

    // Stage 5: threshold rules, priority rocky > sparse > camp > grassland
    always_comb
    begin
        side_next.moisture  = hash_moist[23:0];
        side_next.roughness = hash_rough[23:0];
        side_next.elevation = hash_elev[23:0];
        if (side_next.roughness > RHBC_ROCKY_TH)
        begin
            side_next.slot = rocky_slot_reg;
            fall_key_next  = RHBC_KEY_ROCKY;
        end
        else if (side_next.moisture < RHBC_SPARSE_TH)
        begin
            side_next.slot = sparse_slot_reg;
            fall_key_next  = RHBC_KEY_SPARSE;
        end
        else if (side_next.elevation > RHBC_ELEV_TH && side_next.moisture > RHBC_MOIST_TH)
        begin
            side_next.slot = camp_slot_reg;
            fall_key_next  = RHBC_KEY_CAMP;
        end
        else
        begin
            side_next.slot = grassland_slot_reg;
            fall_key_next  = RHBC_KEY_GRASS;
        end
        side_next.slot_hit = side_next.slot < count;
    end

    // Side info rides along with the fallback hash and modulo stages
    always_ff @(posedge clk)
    begin
        side_reg[0]  <= side_next;
        fall_key_reg <= fall_key_next;
        for (int i = 1; i <= SIDE_DEPTH; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    // Stages 6-7: fallback hash with the class salt
    rhbc_mix u_mix_fall
    (
        .clk      (clk),
        .base     (base_d3_reg),
        .salt_key (fall_key_reg),
        .hash     (hash_fall)
    );

    // Stages 8-15: hash modulo count
    rhbc_mod u_mod
    (
        .clk       (clk),
        .dividend  (hash_fall),
        .divisor   (count),
        .remainder (mod_rem)
    );

    // Stage 16: pick slot or fallback, clamp, empty table override
    always_comb
    begin
        idx = side_reg[SIDE_DEPTH].slot_hit ? side_reg[SIDE_DEPTH].slot : mod_rem;
        if (idx > count - 5'd1)
        begin
            idx = count - 5'd1;
        end
        if (count == 5'd0)
        begin
            result_next             = '0;
            result_next.table_empty = 1'b1;
        end
        else
        begin
            result_next.biome_index = idx[3:0];
            result_next.table_empty = 1'b0;
            result_next.moisture    = side_reg[SIDE_DEPTH].moisture;
            result_next.roughness   = side_reg[SIDE_DEPTH].roughness;
            result_next.elevation   = side_reg[SIDE_DEPTH].elevation;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

`ifndef SYNTHESIS
    // Every accepted word comes out exactly once, a fixed latency later
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##RHBC_LATENCY done)
        else $error("accepted word did not produce a result");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, RHBC_LATENCY))
        else $error("result strobe without an accepted word");

    // Empty table gives a zero index and zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        done && result.table_empty |-> result.biome_index == 4'd0
            && result.moisture == 24'd0 && result.roughness == 24'd0
            && result.elevation == 24'd0)
        else $error("empty table result not cleared");

    // Chosen index stays inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.table_empty && count <= 5'd16 |-> {1'b0, result.biome_index} < count)
        else $error("biome index beyond table");
`endif

endmodule

[sim/rhbc_checker.sv]
`timescale 1ns / 1ps

module rhbc_checker
    import rhbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  rhbc_in_t    item,
    input  logic        done,
    input  rhbc_out_t   result,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          outstanding,
    output int          fail_count,
    output int          words_checked
);

    // Hash multipliers
    localparam logic [31:0] MIX_X    = 32'h9e3779b1;
    localparam logic [31:0] MIX_Z    = 32'h85ebca6b;
    localparam logic [31:0] MIX_SEED = 32'h27d4eb2d;
    localparam logic [31:0] MIX_SALT = 32'hc2b2ae35;
    localparam logic [31:0] MIX_FIN1 = 32'h7feb352d;
    localparam logic [31:0] MIX_FIN2 = 32'h846ca68b;

    // Salts per fraction and per fallback class
    localparam logic [31:0] SALT_MOIST  = 32'd17;
    localparam logic [31:0] SALT_ROUGH  = 32'd41;
    localparam logic [31:0] SALT_ELEV   = 32'd73;
    localparam logic [31:0] SALT_ROCKY  = 32'd3;
    localparam logic [31:0] SALT_SPARSE = 32'd5;
    localparam logic [31:0] SALT_CAMP   = 32'd7;
    localparam logic [31:0] SALT_GRASS  = 32'd11;

    // Class thresholds in percent of full scale
    localparam logic [63:0] FULL_SCALE     = 64'd16777215;
    localparam logic [63:0] ROCKY_PCT      = 64'd68;
    localparam logic [63:0] SPARSE_PCT     = 64'd28;
    localparam logic [63:0] CAMP_ELEV_PCT  = 64'd72;
    localparam logic [63:0] CAMP_MOIST_PCT = 64'd45;

    localparam logic [24:0] SCALE_FLOOR = 25'd66;
    localparam logic [4:0]  TABLE_MAX   = 5'd16;

    // Shadow copy of the register file
    logic [31:0] seed_q;
    logic [24:0] scale_q;
    logic [4:0]  count_q;
    logic [4:0]  rocky_q;
    logic [4:0]  sparse_q;
    logic [4:0]  camp_q;
    logic [4:0]  grass_q;

    rhbc_out_t pending_biomes[$];
    int        mismatches;
    int        checked;

    function automatic logic [31:0] region_mix(input logic [31:0] cx, input logic [31:0] cz,
                                               input logic [31:0] salt);
        logic [31:0] v;
        v = cx * MIX_X;
        v = v ^ (cz * MIX_Z);
        v = v ^ (seed_q * MIX_SEED);
        v = v ^ (salt * MIX_SALT);
        v = v ^ (v >> 16);
        v = v * MIX_FIN1;
        v = v ^ (v >> 15);
        v = v * MIX_FIN2;
        v = v ^ (v >> 16);
        return v;
    endfunction

    // Signed Q16.16 times unsigned Q16.16, floored, wrapped to 32 bits
    function automatic logic [31:0] world_to_cell(input logic [31:0] raw,
                                                  input logic [24:0] scale);
        logic [63:0] prod;
        prod = {{32{raw[31]}}, raw} * {39'd0, scale};
        return prod[63:32];
    endfunction

    function automatic logic frac_over(input logic [23:0] h, input logic [63:0] pct);
        return ({40'd0, h} * 64'd100) > (pct * FULL_SCALE);
    endfunction

    function automatic logic frac_under(input logic [23:0] h, input logic [63:0] pct);
        return ({40'd0, h} * 64'd100) < (pct * FULL_SCALE);
    endfunction

    function automatic rhbc_out_t classify_position(input rhbc_in_t pos);
        rhbc_out_t   res;
        logic [4:0]  count;
        logic [24:0] scale;
        logic [31:0] cx;
        logic [31:0] cz;
        logic [31:0] h;
        logic [23:0] moist;
        logic [23:0] rough;
        logic [23:0] elev;
        logic [4:0]  slot;
        logic [31:0] salt;
        logic [31:0] idx;
        res = '0;
        count = (count_q > TABLE_MAX) ? TABLE_MAX : count_q;
        // empty table: default word
        if (count == 5'd0)
        begin
            res.table_empty = 1'b1;
            return res;
        end
        scale = (scale_q < SCALE_FLOOR) ? SCALE_FLOOR : scale_q;
        cx = world_to_cell(pos.world_x, scale);
        cz = world_to_cell(pos.world_z, scale);
        h = region_mix(cx, cz, SALT_MOIST);
        moist = h[23:0];
        h = region_mix(cx, cz, SALT_ROUGH);
        rough = h[23:0];
        h = region_mix(cx, cz, SALT_ELEV);
        elev = h[23:0];
        // priority: rocky, sparse, camp, grassland
        if (frac_over(rough, ROCKY_PCT))
        begin
            slot = rocky_q;
            salt = SALT_ROCKY;
        end
        else if (frac_under(moist, SPARSE_PCT))
        begin
            slot = sparse_q;
            salt = SALT_SPARSE;
        end
        else if (frac_over(elev, CAMP_ELEV_PCT) && frac_over(moist, CAMP_MOIST_PCT))
        begin
            slot = camp_q;
            salt = SALT_CAMP;
        end
        else
        begin
            slot = grass_q;
            salt = SALT_GRASS;
        end
        // slot outside the table falls back to the class hash
        if (slot < count)
            idx = {27'd0, slot};
        else
            idx = region_mix(cx, cz, salt) % {27'd0, count};
        if (idx > {27'd0, count} - 32'd1)
            idx = {27'd0, count} - 32'd1;
        res.biome_index = idx[3:0];
        res.moisture    = moist;
        res.roughness   = rough;
        res.elevation   = elev;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Compare done words, queue predictions for accepted words, track register writes
    always @(posedge clk or negedge rst_n)
    begin
        rhbc_out_t want;
        if (!rst_n)
        begin
            seed_q   <= '0;
            scale_q  <= 25'd65536;
            count_q  <= '0;
            rocky_q  <= 5'd16;
            sparse_q <= 5'd16;
            camp_q   <= 5'd16;
            grass_q  <= 5'd16;
            pending_biomes.delete();
            mismatches = 0;
            checked = 0;
            outstanding   <= 0;
            fail_count    <= 0;
            words_checked <= 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_biomes.size() == 0)
                begin
                    $error("result word with nothing expected: %p", result);
                    mismatches++;
                end
                else
                begin
                    want = pending_biomes.pop_front();
                    checked++;
                    check_field("biome_index", {20'd0, want.biome_index},
                                {20'd0, result.biome_index});
                    check_field("table_empty", {23'd0, want.table_empty},
                                {23'd0, result.table_empty});
                    check_field("moisture", want.moisture, result.moisture);
                    check_field("roughness", want.roughness, result.roughness);
                    check_field("elevation", want.elevation, result.elevation);
                end
            end

            if (start && !busy)
                pending_biomes = {pending_biomes, classify_position(item)};

            if (cfg_write)
            begin
                case (rhbc_reg_t'(cfg_index))
                    REG_SEED:           seed_q   <= cfg_data;
                    REG_REGION_SCALE:   scale_q  <= cfg_data[24:0];
                    REG_BIOME_COUNT:    count_q  <= cfg_data[4:0];
                    REG_ROCKY_SLOT:     rocky_q  <= cfg_data[4:0];
                    REG_SPARSE_SLOT:    sparse_q <= cfg_data[4:0];
                    REG_CAMP_SLOT:      camp_q   <= cfg_data[4:0];
                    REG_GRASSLAND_SLOT: grass_q  <= cfg_data[4:0];
                    default: ;
                endcase
            end

            outstanding   <= pending_biomes.size();
            fail_count    <= mismatches;
            words_checked <= checked;
        end
    end

endmodule

[sim/tb_region_hash_biome_classifier.sv]
`timescale 1ns / 1ps

module tb_region_hash_biome_classifier;
    import rhbc_pkg::*;

    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 80;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    rhbc_in_t    item;
    logic        done;
    rhbc_out_t   result;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    int outstanding;
    int fail_count;
    int words_checked;
    int positions_sent;
    int settings_used;

    region_hash_biome_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rhbc_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .done          (done),
        .result        (result),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .outstanding   (outstanding),
        .fail_count    (fail_count),
        .words_checked (words_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop
    initial
    begin
        #2_000_000;
        $display("Run timed out with %0d words outstanding", outstanding);
        $display("FAILURE");
        $finish;
    end

    // Coordinates at the edges of the Q16.16 range and around cell boundaries
    function automatic logic [31:0] edge_coord(input int k);
        case (k % 8)
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h8000_0000;
            3:       return 32'h7fff_ffff;
            4:       return 32'h0001_0000;
            5:       return 32'hffff_0000;
            6:       return 32'h0000_8000;
            default: return 32'h5555_aaaa;
        endcase
    endfunction

    // Mostly full-range, some near the origin, some extremes
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(9))
            0:       return edge_coord($urandom_range(7));
            1, 2, 3: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_position(input logic [31:0] x, input logic [31:0] z, input int gap_pct);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item.world_x <= x;
        item.world_z <= z;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        positions_sent++;
    endtask

    // Hold off until every word in flight has come back
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic write_reg(input rhbc_reg_t idx, input logic [31:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [31:0] seed, input logic [31:0] scale,
                                 input logic [31:0] count, input logic [31:0] rocky,
                                 input logic [31:0] sparse, input logic [31:0] camp,
                                 input logic [31:0] grass);
        write_reg(REG_SEED, seed);
        write_reg(REG_REGION_SCALE, scale);
        write_reg(REG_BIOME_COUNT, count);
        write_reg(REG_ROCKY_SLOT, rocky);
        write_reg(REG_SPARSE_SLOT, sparse);
        write_reg(REG_CAMP_SLOT, camp);
        write_reg(REG_GRASSLAND_SLOT, grass);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        int idle_pct;
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_write = 1'b0;
        cfg_index = REG_SEED;
        cfg_data  = '0;
        positions_sent = 0;
        settings_used  = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset registers: empty table
        send_position(32'h0000_0000, 32'h0000_0000, 0);
        send_position(32'h7fff_ffff, 32'h8000_0000, 0);
        send_position($urandom, $urandom, 0);
        wait_drained();

        // Full table, every class in its own slot, edge coordinates
        load_settings($urandom, 32'd65536, 32'd16, 32'd0, 32'd1, 32'd2, 32'd3);
        for (int i = 0; i < 8; i++)
        begin
            send_position(edge_coord(i), edge_coord(i), 0);
            send_position(edge_coord(i), edge_coord(7 - i), 0);
        end
        wait_drained();

        // Scale below the floor, oversized count, all slots absent
        load_settings(32'hffff_ffff, 32'd0, 32'd31, 32'd16, 32'd16, 32'd16, 32'd16);
        for (int i = 0; i < 3; i++)
            send_position(edge_coord(i + 2), edge_coord(i + 3), 0);
        wait_drained();

        // Maximum scale (cell wrap), some slots past the count
        load_settings($urandom, 32'h01ff_ffff, 32'd7, 32'd6, 32'd7, 32'd31, 32'd0);
        for (int i = 0; i < 3; i++)
            send_position(edge_coord(2 * i + 1), edge_coord(2 * i + 2), 0);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            case (p)
                0: load_settings($urandom, 32'd65536, 32'd16, 32'd0, 32'd1, 32'd2, 32'd3);
                1: load_settings(32'hffff_ffff, 32'd0, 32'd1, $urandom_range(31),
                                 $urandom_range(31), $urandom_range(31), $urandom_range(31));
                2: load_settings($urandom, 32'h01ff_ffff, 32'd31, 32'd16, 32'd16, 32'd16,
                                 32'd16);
                3: load_settings($urandom, 32'd66, 32'd5, $urandom_range(31),
                                 $urandom_range(31), $urandom_range(31), $urandom_range(31));
                4: load_settings(32'd0, 32'h0100_0000, 32'd16, 32'd15, 32'd31, 32'd4, 32'd16);
                // upper data bits beyond each register are don't-care
                5: load_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom);
                6: load_settings($urandom, $urandom_range(32'h01ff_ffff), 32'd0,
                                 $urandom_range(31), $urandom_range(31), $urandom_range(31),
                                 $urandom_range(31));
                default: load_settings($urandom, $urandom_range(32'h0002_0000),
                                       $urandom_range(1, 16), $urandom_range(16),
                                       $urandom_range(16), $urandom_range(16),
                                       $urandom_range(16));
            endcase
            idle_pct = (p % 3 == 1) ? 84 : ((p % 3 == 2) ? 11 : 0);
            for (int i = 0; i < WORDS_PER_PHASE; i++)
            begin
                if (i == WORDS_PER_PHASE / 2)
                    wait_drained();
                // back-to-back stretch at the start of each half-phase
                send_position(pick_coord(), pick_coord(), (i % 40 < 10) ? 0 : idle_pct);
            end
        end

        wait_drained();
        repeat (RHBC_LATENCY + 4) @(posedge clk);

        $display("Compared %0d result words for %0d positions over %0d register settings.",
                 words_checked, positions_sent, settings_used);
        $display("Covered empty and oversized tables, absent slots, scale floor and maximum,");
        $display("edge coordinates and sender gaps of 0, 11 and 84 percent.");
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
